FILE: rtl/core/parq_pkg.sv
// Package for the priority run queue: request/result payload types,
// command and status codes, default sizes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package parq_pkg;

    // Default sizes
    localparam int DEF_LEVELS      = 4;
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_ID_BITS     = 8;

    // Fixed payload widths
    localparam int CMD_W   = 2;
    localparam int TID_W   = 8;
    localparam int PRIO_W  = 2;
    localparam int SPRIO_W = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQ     = 2'd0,
        CMD_PREEMPT = 2'd1,
        CMD_DEQ     = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [TID_W-1:0]   task_id;
        logic [PRIO_W-1:0]  prio;
        logic [SPRIO_W-1:0] static_prio;
    } t_req;

    typedef struct packed {
        logic              valid_res;
        logic [TID_W-1:0]  next_id;
        logic [PRIO_W-1:0] new_prio;
        logic              went_expired;
        t_status           status;
    } t_res;

endpackage

`default_nettype wire

FILE: rtl/core/parq_stream_if.sv
// Valid/ready channel carrying one payload of a given type.
// Depends on nothing; payload types come from parq_pkg at instantiation.
`timescale 1ns / 1ps
`default_nettype none

interface parq_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/parq_store.sv
// Task id store for all FIFOs of both banks: one port, registered read.
// Depends on nothing outside this file.
`timescale 1ns / 1ps
`default_nettype none

module parq_store #(
    parameter int ADDR_W = 7,
    parameter int DATA_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic [DATA_W-1:0] i_wdata,
    output logic      [DATA_W-1:0] o_rdata
);
    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    // Write the tail slot on a push
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    // Read the head slot on a pop; the read data is registered
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/core/priority_active_expired_runqueue_core.sv
// Run queue with LEVELS priority levels and active/expired FIFO banks.
// Depends on parq_pkg, parq_stream_if and parq_store.
//
//   channel  dir  payload  handshake
//   i_req    in   t_req    valid/ready, taken when both high
//   o_res    out  t_res    valid/ready, one result per request
//
// On acceptance the FIFO pointers, counts and bank select update while
// the store is written or read, and the result enters the output register
// in the next cycle with the store read data.
// A new request is not taken while the previous one is in the read stage.
// Reset clears pointers, counts and bank select at once; the store is not
// cleared, since a slot is read only after it has been written.
// A stalled result holds in the output register and blocks new requests.
`timescale 1ns / 1ps
`default_nettype none

module priority_active_expired_runqueue_core #(
    parameter int LEVELS      = parq_pkg::DEF_LEVELS,
    parameter int QUEUE_DEPTH = parq_pkg::DEF_QUEUE_DEPTH,
    parameter int ID_BITS     = parq_pkg::DEF_ID_BITS
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    parq_stream_if.sink   i_req,
    parq_stream_if.source o_res
);
    import parq_pkg::*;

    localparam int LVL_W  = $clog2(LEVELS);
    localparam int SLOT_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W = 1 + LVL_W + SLOT_W;
    localparam logic [CNT_W-1:0]  DEPTH_C   = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W:0]    DEPTH_SUM = (CNT_W+1)'(QUEUE_DEPTH);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(QUEUE_DEPTH - 1);
    localparam logic [LVL_W-1:0]  TOP_LVL   = LVL_W'(LEVELS - 1);

    // Saturate a level to the top level
    function automatic logic [LVL_W-1:0] clamp_lvl(input logic [SPRIO_W-1:0] v);
        logic [LVL_W-1:0] res;
        if (int'(v) > LEVELS - 1) begin
            res = TOP_LVL;
        end else begin
            res = LVL_W'(v);
        end
        return res;
    endfunction

    // Queue state
    logic                 r_bank;
    logic [CNT_W-1:0]     r_count [2][LEVELS];
    logic [SLOT_W-1:0]    r_head  [2][LEVELS];

    // Pipeline and output registers
    logic                 r_s1_vld;
    t_res                 r_s1;
    logic                 r_out_vld;
    t_res                 r_out;

    t_req                 w_req;
    logic                 w_acc;
    logic                 w_active_empty;
    logic                 w_other_empty;
    logic                 w_all_empty;
    logic                 w_bank_d;
    logic                 w_hit;
    logic [LVL_W-1:0]     w_lvl_d;
    logic [SLOT_W-1:0]    w_head_d;
    logic [SLOT_W-1:0]    w_head_nxt;
    logic                 w_bank_p;
    logic [LVL_W-1:0]     w_lvl_p;
    logic                 w_expired;
    logic [CNT_W-1:0]     w_cnt_p;
    logic                 w_full;
    logic [CNT_W:0]       w_sum;
    logic [SLOT_W-1:0]    w_slot;
    logic                 w_is_push;
    logic                 w_is_deq;
    logic                 w_mem_we;
    logic                 w_mem_re;
    logic [ADDR_W-1:0]    w_mem_addr;
    logic [ID_BITS-1:0]   w_rdata;
    t_res                 n_s1;
    t_res                 n_out;
    logic                 w_cnt_ovf;

    assign w_req       = i_req.payload;
    assign i_req.ready = !r_s1_vld && (!r_out_vld || o_res.ready);
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_is_push   = (w_req.command == CMD_ENQ) || (w_req.command == CMD_PREEMPT);
    assign w_is_deq    = (w_req.command == CMD_DEQ);

    // Bank occupancy and highest non-empty level of the dequeue bank
    always_comb begin
        w_active_empty = 1'b1;
        w_other_empty  = 1'b1;
        w_cnt_ovf      = 1'b0;
        for (int l = 0; l < LEVELS; l++) begin
            if (r_count[r_bank][l] != '0) begin
                w_active_empty = 1'b0;
            end
            if (r_count[!r_bank][l] != '0) begin
                w_other_empty = 1'b0;
            end
            if (r_count[0][l] > DEPTH_C || r_count[1][l] > DEPTH_C) begin
                w_cnt_ovf = 1'b1;
            end
        end
        w_all_empty = w_active_empty && w_other_empty;
        w_bank_d    = w_active_empty ? !r_bank : r_bank;
        w_hit       = 1'b0;
        w_lvl_d     = '0;
        for (int l = 0; l < LEVELS; l++) begin
            if (r_count[w_bank_d][l] != '0) begin
                w_hit   = 1'b1;
                w_lvl_d = LVL_W'(l);
            end
        end
        w_head_d   = r_head[w_bank_d][w_lvl_d];
        w_head_nxt = (w_head_d == LAST_SLOT) ? '0 : w_head_d + 1'b1;
    end

    // Target FIFO of a push, with priority decay for a preempted task
    always_comb begin
        w_bank_p  = r_bank;
        w_lvl_p   = clamp_lvl(SPRIO_W'(w_req.prio));
        w_expired = 1'b0;
        if (w_req.command == CMD_PREEMPT) begin
            if (w_req.prio == '0) begin
                w_bank_p  = !r_bank;
                w_expired = 1'b1;
                w_lvl_p   = (w_req.static_prio == '0) ? '0
                                                      : clamp_lvl(w_req.static_prio - 1'b1);
            end else begin
                w_lvl_p = clamp_lvl(SPRIO_W'(w_req.prio - 1'b1));
            end
        end
        w_cnt_p = r_count[w_bank_p][w_lvl_p];
        w_full  = (w_cnt_p >= DEPTH_C);
        w_sum   = (CNT_W+1)'(r_head[w_bank_p][w_lvl_p]) + (CNT_W+1)'(w_cnt_p);
        if (w_sum >= DEPTH_SUM) begin
            w_sum = w_sum - DEPTH_SUM;
        end
        w_slot = SLOT_W'(w_sum);
    end

    // Store access: tail write on push, head read on pop
    assign w_mem_we   = w_acc && w_is_push && !w_full;
    assign w_mem_re   = w_acc && w_is_deq && w_hit;
    assign w_mem_addr = w_is_deq ? {w_bank_d, w_lvl_d, w_head_d}
                                 : {w_bank_p, w_lvl_p, w_slot};

    parq_store #(
        .ADDR_W (ADDR_W),
        .DATA_W (ID_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_re    (w_mem_re),
        .i_addr  (w_mem_addr),
        .i_wdata (ID_BITS'(w_req.task_id)),
        .o_rdata (w_rdata)
    );

    // Result fields known at acceptance
    always_comb begin
        n_s1 = '0;
        unique case (w_req.command)
            CMD_ENQ: begin
                n_s1.new_prio = w_req.prio;
                n_s1.status   = w_full ? ST_FULL : ST_OK;
            end
            CMD_PREEMPT: begin
                n_s1.new_prio     = PRIO_W'(w_lvl_p);
                n_s1.went_expired = w_expired;
                n_s1.status       = w_full ? ST_FULL : ST_OK;
            end
            CMD_DEQ: begin
                n_s1.new_prio  = w_req.prio;
                n_s1.valid_res = w_hit;
                n_s1.status    = w_hit ? ST_OK : ST_EMPTY;
            end
            default: begin
                n_s1 = '0;
            end
        endcase
    end

    // Update counts, heads and bank select on an accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank <= 1'b0;
            for (int b = 0; b < 2; b++) begin
                for (int l = 0; l < LEVELS; l++) begin
                    r_count[b][l] <= '0;
                    r_head[b][l]  <= '0;
                end
            end
        end else if (w_acc) begin
            unique case (w_req.command)
                CMD_ENQ: begin
                    if (!w_full) begin
                        r_count[w_bank_p][w_lvl_p] <= w_cnt_p + 1'b1;
                    end
                end
                CMD_PREEMPT: begin
                    if (!w_full) begin
                        r_count[w_bank_p][w_lvl_p] <= w_cnt_p + 1'b1;
                    end
                    // active bank stays empty only when the task went expired
                    if (w_active_empty && w_expired) begin
                        r_bank <= !r_bank;
                    end
                end
                CMD_DEQ: begin
                    r_bank <= w_bank_d;
                    if (w_hit) begin
                        r_count[w_bank_d][w_lvl_d] <= r_count[w_bank_d][w_lvl_d] - 1'b1;
                        r_head[w_bank_d][w_lvl_d]  <= w_head_nxt;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Advance the request through the read stage into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld <= w_acc;
            if (r_s1_vld) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Merge the store read data into the result
    always_comb begin
        n_out         = r_s1;
        n_out.next_id = r_s1.valid_res ? TID_W'(w_rdata) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1 <= n_s1;
        end
        if (r_s1_vld) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid   = r_out_vld;
    assign o_res.payload = r_out;

`ifndef SYNTHESIS
    // No FIFO ever holds more than its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_cnt_ovf)
        else $error("fifo count above depth");

    // An empty dequeue means both banks were empty
    a_empty_deq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_is_deq && !w_hit) |=> w_all_empty)
        else $error("empty dequeue while tasks are queued");

    // A stalled result is never overwritten by the read stage
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_res.ready) |-> !r_s1_vld)
        else $error("output register overwritten while stalled");

    // A returned task always reports success
    a_res_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.valid_res) |-> (r_out.status == ST_OK))
        else $error("dequeued task with error status");

    // After a pop that finds no task the active bank is empty only if the whole queue is
    a_bank_swap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_is_deq) |=> (!w_active_empty || w_other_empty
                                 || $past(w_hit)))
        else $error("active bank left empty while expired bank holds tasks");
`endif

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking bench for priority_active_expired_runqueue_core: drives requests
// through the request channel and checks every result against a run-queue predictor.
// Depends on parq_pkg, parq_stream_if and the core RTL.
`timescale 1ns / 1ps

import parq_pkg::*;

// Track the active and expired banks and compare each result with the oldest expectation
class runqueue_scoreboard;
    localparam int NUM_FIFOS = 2 * DEF_LEVELS;

    logic [TID_W-1:0] fifo_ids [NUM_FIFOS][DEF_QUEUE_DEPTH];
    int unsigned      fifo_head [NUM_FIFOS];
    int unsigned      fifo_count [NUM_FIFOS];
    bit               active_bank;
    t_res             expected_results [$];
    int               mismatches;

    function new();
        foreach (fifo_head[f]) begin
            fifo_head[f]  = 0;
            fifo_count[f] = 0;
        end
        active_bank = 1'b0;
        mismatches  = 0;
    endfunction

    function int clamp_level(int v);
        return (v > DEF_LEVELS - 1) ? DEF_LEVELS - 1 : v;
    endfunction

    function int fifo_of(bit bank, int level);
        return bank * DEF_LEVELS + level;
    endfunction

    // Append at the tail; refuse when the level is full
    function bit push_task(int f, logic [TID_W-1:0] id);
        if (fifo_count[f] >= DEF_QUEUE_DEPTH) return 1'b0;
        fifo_ids[f][(fifo_head[f] + fifo_count[f]) % DEF_QUEUE_DEPTH] = id;
        fifo_count[f]++;
        return 1'b1;
    endfunction

    // Swap roles once the active bank runs dry
    function void swap_if_drained();
        for (int l = 0; l < DEF_LEVELS; l++)
            if (fifo_count[fifo_of(active_bank, l)] != 0) return;
        active_bank = ~active_bank;
    endfunction

    // Predict the result of an accepted request and queue it
    function void note_request(t_req r);
        t_res e;
        int   lvl;
        bit   bank;
        int   f;
        e = '0;
        case (t_cmd'(r.command))
            CMD_ENQ: begin
                lvl = clamp_level(int'(r.prio));
                e.new_prio = r.prio;
                if (!push_task(fifo_of(active_bank, lvl), r.task_id)) e.status = ST_FULL;
            end
            CMD_PREEMPT: begin
                if (r.prio == 0) begin
                    lvl  = (r.static_prio == 0) ? 0 : clamp_level(int'(r.static_prio) - 1);
                    bank = ~active_bank;
                    e.went_expired = 1'b1;
                end else begin
                    lvl  = clamp_level(int'(r.prio) - 1);
                    bank = active_bank;
                end
                e.new_prio = PRIO_W'(lvl);
                if (!push_task(fifo_of(bank, lvl), r.task_id)) e.status = ST_FULL;
                swap_if_drained();
            end
            CMD_DEQ: begin
                e.new_prio = r.prio;
                swap_if_drained();
                e.status = ST_EMPTY;
                for (int l = DEF_LEVELS - 1; l >= 0; l--) begin
                    f = fifo_of(active_bank, l);
                    if (fifo_count[f] != 0) begin
                        e.next_id    = fifo_ids[f][fifo_head[f]];
                        fifo_head[f] = (fifo_head[f] + 1) % DEF_QUEUE_DEPTH;
                        fifo_count[f]--;
                        e.valid_res  = 1'b1;
                        e.status     = ST_OK;
                        break;
                    end
                end
            end
            default: ;  // unused code: no state change, all-zero result
        endcase
        expected_results = {expected_results, e};
    endfunction

    function void compare_field(string name, logic [7:0] expv, logic [7:0] gotv);
        if (gotv !== expv) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, expv, gotv);
            mismatches++;
        end
    endfunction

    // Compare a delivered result with the oldest expectation
    function void check_result(t_res got);
        t_res e;
        if (expected_results.size() == 0) begin
            $display("%0t: unexpected result %h, expected none", $time, got);
            mismatches++;
            return;
        end
        e = expected_results.pop_front();
        compare_field("valid_res", 8'(e.valid_res), 8'(got.valid_res));
        compare_field("next_id", e.next_id, got.next_id);
        compare_field("new_prio", 8'(e.new_prio), 8'(got.new_prio));
        compare_field("went_expired", 8'(e.went_expired), 8'(got.went_expired));
        compare_field("status", 8'(e.status), 8'(got.status));
    endfunction

    function int pending();
        return expected_results.size();
    endfunction
endclass

module testbench;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_REQUESTS = 1400;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int SETTLE_CYCLES   = 20;
    localparam int HOLD_AFTER      = 200;
    localparam int HOLD_CYCLES     = 400;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} t_mix;

    logic i_clk;
    logic i_rst_n;
    bit   steady_send;
    int   cycles;

    parq_stream_if #(.t_payload(t_req)) req_if ();
    parq_stream_if #(.t_payload(t_res)) res_if ();

    runqueue_scoreboard sb;

    priority_active_expired_runqueue_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly short gaps, a few long ones
    function int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    function t_req make_req(logic [CMD_W-1:0] cmd, logic [TID_W-1:0] id,
                            logic [PRIO_W-1:0] prio, logic [SPRIO_W-1:0] sprio);
        t_req r;
        r.command     = cmd;
        r.task_id     = id;
        r.prio        = prio;
        r.static_prio = sprio;
        return r;
    endfunction

    // Draw a request; hot below DEF_LEVELS concentrates traffic on one level
    function t_req random_request(t_mix mix, int hot);
        int               r;
        logic [CMD_W-1:0] cmd;
        logic [PRIO_W-1:0] prio;
        logic [SPRIO_W-1:0] sprio;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  cmd = (r < 55) ? CMD_ENQ : (r < 85) ? CMD_PREEMPT :
                             (r < 95) ? CMD_DEQ : CMD_UNUSED;
            MIX_DRAIN: cmd = (r < 15) ? CMD_ENQ : (r < 25) ? CMD_PREEMPT :
                             (r < 97) ? CMD_DEQ : CMD_UNUSED;
            default:   cmd = (r < 35) ? CMD_ENQ : (r < 55) ? CMD_PREEMPT :
                             (r < 95) ? CMD_DEQ : CMD_UNUSED;
        endcase
        if (hot < DEF_LEVELS && $urandom_range(0, 99) < 70) prio = PRIO_W'(hot);
        else prio = PRIO_W'($urandom_range(0, 3));
        if ($urandom_range(0, 4) != 0) sprio = SPRIO_W'($urandom_range(1, 4));
        else sprio = SPRIO_W'($urandom_range(0, 7));
        return make_req(cmd, TID_W'($urandom_range(0, 255)), prio, sprio);
    endfunction

    // Offer one request after an optional gap and hold it until accepted
    task automatic send_request(t_req r);
        int gap;
        gap = steady_send ? 0 : idle_len();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= r;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request(r);
    endtask

    // Receive results with random stalls and one long hold-off
    initial begin : result_sink
        int  stall_left;
        int  taken;
        int  sink_cycles;
        bit  steady;
        bit  held;
        stall_left   = 0;
        taken        = 0;
        sink_cycles  = 0;
        steady       = 1'b0;
        held         = 1'b0;
        res_if.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            @(posedge i_clk);
            if (res_if.valid && res_if.ready) begin
                sb.check_result(res_if.payload);
                taken++;
            end
            sink_cycles++;
            if (sink_cycles % 250 == 0) steady = ($urandom_range(0, 3) == 0);
            if (!held && taken >= HOLD_AFTER) begin
                held       = 1'b1;
                stall_left = HOLD_CYCLES;
            end else if (stall_left > 0) begin
                stall_left--;
            end else if (!steady && $urandom_range(0, 3) == 0) begin
                stall_left = idle_len();
            end
            res_if.ready <= (stall_left == 0);
        end
    end

    // Stop a hung run
    initial begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin : request_source
        t_req r;
        t_mix mix;
        int   hot;
        int   counted;
        int   n;
        sb             = new();
        steady_send    = 1'b0;
        req_if.valid   <= 1'b0;
        req_if.payload <= '0;
        i_rst_n        <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty dequeue, expiry and swap, saturation, every level, unused code
        send_request(make_req(CMD_DEQ, 8'hFF, 2'd3, 3'd7));
        send_request(make_req(CMD_PREEMPT, 8'h00, 2'd0, 3'd0));
        send_request(make_req(CMD_PREEMPT, 8'hFF, 2'd0, 3'd7));
        send_request(make_req(CMD_ENQ, 8'hA5, 2'd3, 3'd4));
        send_request(make_req(CMD_ENQ, 8'h5A, 2'd0, 3'd1));
        send_request(make_req(CMD_ENQ, 8'h3C, 2'd1, 3'd2));
        send_request(make_req(CMD_ENQ, 8'hC3, 2'd2, 3'd3));
        send_request(make_req(CMD_PREEMPT, 8'h11, 2'd3, 3'd1));
        send_request(make_req(CMD_PREEMPT, 8'h22, 2'd1, 3'd4));
        send_request(make_req(CMD_PREEMPT, 8'h33, 2'd0, 3'd4));
        send_request(make_req(CMD_PREEMPT, 8'h44, 2'd0, 3'd1));
        send_request(make_req(CMD_UNUSED, 8'hFF, 2'd3, 3'd7));
        send_request(make_req(CMD_UNUSED, 8'h00, 2'd0, 3'd0));
        for (int i = 0; i < 11; i++)
            send_request(make_req(CMD_DEQ, 8'(i * 23), 2'(i), 3'(i)));

        // Random: phases that fill, drain or mix, often hammering one level
        counted = 0;
        n       = 0;
        mix     = MIX_BALANCED;
        hot     = DEF_LEVELS;
        while (counted < RANDOM_REQUESTS) begin
            if (n % 50 == 0) begin
                mix = t_mix'($urandom_range(0, 2));
                hot = $urandom_range(0, DEF_LEVELS);
            end
            if (n % 150 == 0) steady_send = ($urandom_range(0, 3) == 0);
            r = random_request(mix, hot);
            send_request(r);
            if (r.command != CMD_UNUSED) counted++;
            n++;
        end
        req_if.valid <= 1'b0;

        // Drain outstanding results, then watch for strays
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

FILE: sim.f
rtl/core/parq_pkg.sv
rtl/core/parq_stream_if.sv
rtl/core/parq_store.sv
rtl/core/priority_active_expired_runqueue_core.sv
tb/testbench.sv
